### src/lbdh_pkg.sv
// Shared widths, defaults, record types and helper function of the duration histogram.
package lbdh_pkg;

  localparam int unsigned BUCKETS_DEF         = 10;
  localparam int unsigned BUCKET_SHIFT_DEF    = 2;
  localparam int unsigned FIRST_BUCKET_NS_DEF = 62500;
  localparam int unsigned CATEGORIES_DEF      = 6;

  localparam int unsigned FUNC_W = 1;
  localparam int unsigned CAT_W  = 3;
  localparam int unsigned DUR_W  = 63;
  localparam int unsigned BKT_W  = 4;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned THR_W  = 96;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [DUR_W-1:0] min_ns;
    logic [DUR_W-1:0] max_ns;
  } bkt_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] events;
    logic [DUR_W-1:0] total_ns;
  } cat_rec_t;

  // Lowest duration that falls into bucket k+1 or above.
  function automatic logic [THR_W-1:0] bucket_threshold(int unsigned first_ns,
                                                        int unsigned shift,
                                                        int unsigned k);
    logic [THR_W-1:0] base;
    base = THR_W'(first_ns);
    return base << (shift * k);
  endfunction

endpackage

### src/lbdh_in_if.sv
// Input channel of the duration histogram: valid, ready and the request fields.
interface lbdh_in_if
  import lbdh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CAT_W-1:0]  category;
  logic [DUR_W-1:0]  duration_ns;
  logic [BKT_W-1:0]  read_bucket;

  modport source (output valid, func, category, duration_ns, read_bucket, input ready);
  modport sink (input valid, func, category, duration_ns, read_bucket, output ready);
endinterface

### src/lbdh_out_if.sv
// Output channel of the duration histogram: valid, ready and the result fields.
interface lbdh_out_if
  import lbdh_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [BKT_W-1:0] bucket_index;
  logic [CNT_W-1:0] bucket_hits;
  logic [DUR_W-1:0] bucket_min_ns;
  logic [DUR_W-1:0] bucket_max_ns;
  logic [CNT_W-1:0] category_events;
  logic [DUR_W-1:0] category_total_ns;

  modport source (output valid, bucket_index, bucket_hits, bucket_min_ns, bucket_max_ns,
                  category_events, category_total_ns, input ready);
  modport sink (input valid, bucket_index, bucket_hits, bucket_min_ns, bucket_max_ns,
                category_events, category_total_ns, output ready);
endinterface

### src/log_bucket_duration_histogram.sv
// Per-category logarithmic-bucket duration histogram with bucket and category stores.
//
// Each transaction passes through the states ST_BKT, which compares the duration
// against the bucket thresholds and forms the store address, ST_RD, for the
// synchronous read of the bucket and category memories, and ST_MOD, which updates
// the records, writes them back and loads the output register. A new transaction
// is accepted in ST_MOD, so the next request enters while the last one finishes;
// a stalled output holds the block in ST_RD. The memories are cleared at reset through
// per-entry valid bits, so no clearing pass is needed and the block is ready in
// the first cycle after reset.
module log_bucket_duration_histogram
  import lbdh_pkg::*;
#(
  parameter int unsigned BUCKETS         = BUCKETS_DEF,
  parameter int unsigned BUCKET_SHIFT    = BUCKET_SHIFT_DEF,
  parameter int unsigned FIRST_BUCKET_NS = FIRST_BUCKET_NS_DEF,
  parameter int unsigned CATEGORIES      = CATEGORIES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  lbdh_in_if.sink    in_i,
  lbdh_out_if.source out_o
);

  localparam int unsigned SLOTS  = CATEGORIES * BUCKETS;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CAT_AW = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BKT,
    ST_RD,
    ST_MOD
  } state_e;

  state_e            state_q;
  logic [FUNC_W-1:0] func_q;
  logic [CAT_W-1:0]  cat_q;
  logic [DUR_W-1:0]  dur_q;
  logic [BKT_W-1:0]  rb_q;
  logic [BKT_W-1:0]  bkt_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CAT_AW-1:0] cat_idx_q;
  logic              cat_ok_q;
  logic [SLOTS-1:0]  bkt_vld_q;
  logic [CATEGORIES-1:0] cat_vld_q;

  bkt_rec_t bkt_mem [SLOTS];
  cat_rec_t cat_mem [CATEGORIES];
  bkt_rec_t bkt_rd_q;
  cat_rec_t cat_rd_q;

  logic              out_valid_q;
  logic [BKT_W-1:0]  out_bkt_q;
  bkt_rec_t          out_bkt_rec_q;
  cat_rec_t          out_cat_rec_q;

  logic              in_ready;
  logic              in_fire;
  logic              out_free;
  logic              is_add;
  logic [BKT_W-1:0]  bkt_add_d;
  logic [BKT_W-1:0]  bkt_rd_d;
  logic [BKT_W-1:0]  bkt_d;
  logic              cat_ok_d;
  logic [SLOT_W-1:0] slot_d;
  bkt_rec_t          bkt_old;
  bkt_rec_t          bkt_new;
  cat_rec_t          cat_old;
  cat_rec_t          cat_new;
  bkt_rec_t          res_bkt;
  cat_rec_t          res_cat;
  logic              wr_en;

  assign in_ready = (state_q == ST_IDLE) || (state_q == ST_MOD);
  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign is_add   = (func_q == FUNC_ADD);

  // Bucket selection: the thresholds grow monotonically, so the last one passed wins.
  always_comb begin
    bkt_add_d = '0;
    for (int unsigned k = 0; k < BUCKETS - 1; k++) begin
      if ({{(THR_W - DUR_W){1'b0}}, dur_q} >=
          bucket_threshold(FIRST_BUCKET_NS, BUCKET_SHIFT, k)) begin
        bkt_add_d = BKT_W'(k + 1);
      end
    end
    bkt_rd_d = (32'(rb_q) >= BUCKETS) ? BKT_W'(BUCKETS - 1) : rb_q;
    bkt_d    = is_add ? bkt_add_d : bkt_rd_d;
    cat_ok_d = (32'(cat_q) < CATEGORIES);
    slot_d   = cat_ok_d ? SLOT_W'(32'(cat_q) * BUCKETS + 32'(bkt_d)) : '0;
  end

  always_comb begin
    bkt_old = bkt_vld_q[slot_q] ? bkt_rd_q : '0;
    cat_old = cat_vld_q[cat_idx_q] ? cat_rd_q : '0;

    bkt_new.hits   = bkt_old.hits + 1'b1;
    bkt_new.min_ns = ((dur_q < bkt_old.min_ns) || (bkt_old.max_ns == '0)) ?
                     dur_q : bkt_old.min_ns;
    bkt_new.max_ns = (dur_q > bkt_old.max_ns) ? dur_q : bkt_old.max_ns;
    cat_new.events   = cat_old.events + 1'b1;
    cat_new.total_ns = cat_old.total_ns + dur_q;

    if (!cat_ok_q) begin
      res_bkt = '0;
      res_cat = '0;
    end else if (is_add) begin
      res_bkt = bkt_new;
      res_cat = cat_new;
    end else begin
      res_bkt = bkt_old;
      res_cat = cat_old;
    end
    wr_en = (state_q == ST_MOD) && is_add && cat_ok_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      bkt_rd_q <= bkt_mem[slot_q];
      cat_rd_q <= cat_mem[cat_idx_q];
    end
    if (wr_en) begin
      bkt_mem[slot_q]    <= bkt_new;
      cat_mem[cat_idx_q] <= cat_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      func_q        <= '0;
      cat_q         <= '0;
      dur_q         <= '0;
      rb_q          <= '0;
      bkt_q         <= '0;
      slot_q        <= '0;
      cat_idx_q     <= '0;
      cat_ok_q      <= 1'b0;
      bkt_vld_q     <= '0;
      cat_vld_q     <= '0;
      out_valid_q   <= 1'b0;
      out_bkt_q     <= '0;
      out_bkt_rec_q <= '0;
      out_cat_rec_q <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        func_q <= in_i.func;
        cat_q  <= in_i.category;
        dur_q  <= in_i.duration_ns;
        rb_q   <= in_i.read_bucket;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_BKT;
          end
        end
        ST_BKT: begin
          bkt_q     <= bkt_d;
          slot_q    <= slot_d;
          cat_idx_q <= cat_ok_d ? CAT_AW'(cat_q) : '0;
          cat_ok_q  <= cat_ok_d;
          state_q   <= ST_RD;
        end
        ST_RD: begin
          if (out_free) begin
            state_q <= ST_MOD;
          end
        end
        ST_MOD: begin
          out_valid_q   <= 1'b1;
          out_bkt_q     <= bkt_q;
          out_bkt_rec_q <= res_bkt;
          out_cat_rec_q <= res_cat;
          if (wr_en) begin
            bkt_vld_q[slot_q]    <= 1'b1;
            cat_vld_q[cat_idx_q] <= 1'b1;
          end
          state_q <= in_fire ? ST_BKT : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready              = in_ready;
  assign out_o.valid             = out_valid_q;
  assign out_o.bucket_index      = out_bkt_q;
  assign out_o.bucket_hits       = out_bkt_rec_q.hits;
  assign out_o.bucket_min_ns     = out_bkt_rec_q.min_ns;
  assign out_o.bucket_max_ns     = out_bkt_rec_q.max_ns;
  assign out_o.category_events   = out_cat_rec_q.events;
  assign out_o.category_total_ns = out_cat_rec_q.total_ns;

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BKT || state_q == ST_RD) |-> !in_i.ready)
    else $error("Input accepted while a transaction is in flight.");

  a_mod_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |=> out_valid_q)
    else $error("Update cycle did not load the output register.");

  a_rd_waits_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (!out_valid_q || $past(out_free)))
    else $error("Update cycle entered while the output was still occupied.");

  a_write_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> bkt_vld_q[$past(slot_q)] && cat_vld_q[$past(cat_idx_q)])
    else $error("Written entry not marked valid.");

  a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bkt_rec_q.max_ns != '0) |->
      (out_bkt_rec_q.min_ns <= out_bkt_rec_q.max_ns))
    else $error("Bucket minimum exceeds bucket maximum.");

endmodule
